// ----- hw/rtl/scancode_set1_to_ascii_macros.svh -----
// Assertion helpers shared by the decoder RTL.
`ifndef SCANCODE_SET1_TO_ASCII_MACROS_SVH
`define SCANCODE_SET1_TO_ASCII_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SC1A_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sc1a: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SC1A_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sc1a: next-cycle check failed");

`endif

// ----- hw/rtl/sc1a_pkg.sv -----
package sc1a_pkg;

    localparam int unsigned CHAR_W = 7;

    localparam logic [7:0] PREFIX_BYTE = 8'hE0;
    localparam logic [6:0] MK_CTRL     = 7'h1D;
    localparam logic [6:0] MK_LSHIFT   = 7'h2A;
    localparam logic [6:0] MK_RSHIFT   = 7'h36;
    localparam logic [6:0] MK_ALT      = 7'h38;
    localparam logic [6:0] MK_CAPS     = 7'h3A;
    localparam logic [7:0] LAST_MAKE   = 8'h3A;

    localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_L = 7'h6C;
    localparam logic [CHAR_W-1:0] CH_LOWER_U = 7'h75;

    typedef struct packed {
        logic              char_valid;
        logic [CHAR_W-1:0] char_code;
        logic              unknown_key;
        logic              ctrl_down;
        logic              shift_down;
        logic              alt_down;
        logic              caps_on;
    } t_result;

    // Returns {shifted, plain} for a make code index; zero marks a modifier key or unused code.
    function automatic logic [2*CHAR_W-1:0] key_lookup(input logic [5:0] idx);
        logic [2*CHAR_W-1:0] ent;
        case (idx)
            6'h01: ent = {7'h1B, 7'h1B};
            6'h02: ent = {7'h21, 7'h31};
            6'h03: ent = {7'h40, 7'h32};
            6'h04: ent = {7'h23, 7'h33};
            6'h05: ent = {7'h24, 7'h34};
            6'h06: ent = {7'h25, 7'h35};
            6'h07: ent = {7'h5E, 7'h36};
            6'h08: ent = {7'h26, 7'h37};
            6'h09: ent = {7'h2A, 7'h38};
            6'h0A: ent = {7'h28, 7'h39};
            6'h0B: ent = {7'h29, 7'h30};
            6'h0C: ent = {7'h5F, 7'h2D};
            6'h0D: ent = {7'h2B, 7'h3D};
            6'h0E: ent = {7'h08, 7'h08};
            6'h0F: ent = {7'h09, 7'h09};
            6'h10: ent = {7'h51, 7'h71};
            6'h11: ent = {7'h57, 7'h77};
            6'h12: ent = {7'h45, 7'h65};
            6'h13: ent = {7'h52, 7'h72};
            6'h14: ent = {7'h54, 7'h74};
            6'h15: ent = {7'h59, 7'h79};
            6'h16: ent = {7'h55, 7'h75};
            6'h17: ent = {7'h49, 7'h69};
            6'h18: ent = {7'h4F, 7'h6F};
            6'h19: ent = {7'h50, 7'h70};
            6'h1A: ent = {7'h7B, 7'h5B};
            6'h1B: ent = {7'h7D, 7'h5D};
            6'h1C: ent = {7'h0D, 7'h0D};
            6'h1E: ent = {7'h41, 7'h61};
            6'h1F: ent = {7'h53, 7'h73};
            6'h20: ent = {7'h44, 7'h64};
            6'h21: ent = {7'h46, 7'h66};
            6'h22: ent = {7'h47, 7'h67};
            6'h23: ent = {7'h48, 7'h68};
            6'h24: ent = {7'h4A, 7'h6A};
            6'h25: ent = {7'h4B, 7'h6B};
            6'h26: ent = {7'h4C, 7'h6C};
            6'h27: ent = {7'h3A, 7'h3B};
            6'h28: ent = {7'h22, 7'h27};
            6'h29: ent = {7'h7E, 7'h60};
            6'h2B: ent = {7'h7C, 7'h5C};
            6'h2C: ent = {7'h5A, 7'h7A};
            6'h2D: ent = {7'h58, 7'h78};
            6'h2E: ent = {7'h43, 7'h63};
            6'h2F: ent = {7'h56, 7'h76};
            6'h30: ent = {7'h42, 7'h62};
            6'h31: ent = {7'h4E, 7'h6E};
            6'h32: ent = {7'h4D, 7'h6D};
            6'h33: ent = {7'h3C, 7'h2C};
            6'h34: ent = {7'h3E, 7'h2E};
            6'h35: ent = {7'h3F, 7'h2F};
            6'h37: ent = {7'h2A, 7'h2A};
            6'h39: ent = {7'h20, 7'h20};
            default: ent = '0;
        endcase
        return ent;
    endfunction

    // Digit and punctuation keys follow shift only, not caps lock.
    function automatic logic shift_only_key(input logic [5:0] idx);
        logic res;
        case (idx)
            6'h1A, 6'h1B, 6'h27, 6'h28, 6'h29, 6'h2B, 6'h33, 6'h34, 6'h35: res = 1'b1;
            default: res = (idx < 6'h0E);
        endcase
        return res;
    endfunction

endpackage

// ----- hw/rtl/sc1a_decode.sv -----
`include "scancode_set1_to_ascii_macros.svh"

module sc1a_decode (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_fire,
    input  logic [7:0]              i_byte,
    input  logic                    i_full,
    output sc1a_pkg::t_result       o_result
);
    import sc1a_pkg::*;

    logic r_prefix, r_ctrl, r_shift, r_alt, r_caps;
    logic n_prefix, n_ctrl, n_shift, n_alt, n_caps;

    logic              is_prefix;
    logic              is_break;
    logic              is_make;
    logic [6:0]        mk;
    logic [5:0]        idx;
    logic              col;
    logic [2*CHAR_W-1:0] ent;
    logic [CHAR_W-1:0] ch;
    logic              ch_valid;
    logic              unknown;

    assign is_prefix = (i_byte == PREFIX_BYTE);
    assign is_break  = i_byte[7];
    assign mk        = i_byte[6:0];
    assign idx       = i_byte[5:0];
    assign is_make   = !is_break &&
                       (r_prefix ? (mk == MK_ALT || mk == MK_CTRL)
                                 : (i_byte != 8'h00 && i_byte <= LAST_MAKE));
    // Extended codes never count as shift-only keys.
    assign col       = (!r_prefix && shift_only_key(idx)) ? r_shift : (r_shift ^ r_caps);
    assign ent       = key_lookup(idx);

    always_comb begin
        n_prefix = r_prefix;
        n_ctrl   = r_ctrl;
        n_shift  = r_shift;
        n_alt    = r_alt;
        n_caps   = r_caps;
        ch       = '0;
        ch_valid = 1'b0;
        unknown  = 1'b0;
        if (is_prefix) begin
            n_prefix = 1'b1;
        end else begin
            n_prefix = 1'b0;
            if (is_break) begin
                if (mk == MK_CTRL) begin
                    n_ctrl = 1'b0;
                end else if (!r_prefix && (mk == MK_LSHIFT || mk == MK_RSHIFT)) begin
                    n_shift = 1'b0;
                end else if (mk == MK_ALT) begin
                    n_alt = 1'b0;
                end
            end else if (is_make) begin
                ch = col ? ent[2*CHAR_W-1:CHAR_W] : ent[CHAR_W-1:0];
                if (ch != '0) begin
                    if (r_ctrl && (ch == CH_LOWER_L || ch == CH_LOWER_U)) begin
                        ch = ch - CH_LOWER_A;
                    end
                    if (!i_full) begin
                        ch_valid = 1'b1;
                    end else begin
                        ch = '0;
                    end
                end else if (mk == MK_CTRL) begin
                    n_ctrl = 1'b1;
                end else if (mk == MK_LSHIFT || mk == MK_RSHIFT) begin
                    n_shift = 1'b1;
                end else if (mk == MK_ALT) begin
                    n_alt = 1'b1;
                end else if (mk == MK_CAPS) begin
                    n_caps = !r_caps;
                end
            end else begin
                unknown = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= 1'b0;
            r_ctrl   <= 1'b0;
            r_shift  <= 1'b0;
            r_alt    <= 1'b0;
            r_caps   <= 1'b0;
        end else if (i_fire) begin
            r_prefix <= n_prefix;
            r_ctrl   <= n_ctrl;
            r_shift  <= n_shift;
            r_alt    <= n_alt;
            r_caps   <= n_caps;
        end
    end

    always_comb begin
        o_result.char_valid  = ch_valid;
        o_result.char_code   = ch_valid ? ch : '0;
        o_result.unknown_key = unknown;
        o_result.ctrl_down   = n_ctrl;
        o_result.shift_down  = n_shift;
        o_result.alt_down    = n_alt;
        o_result.caps_on     = n_caps;
    end

    `SC1A_ASSERT_IMP(a_char_not_unknown, i_clk, i_rst_n, o_result.char_valid,
                     !o_result.unknown_key && o_result.char_code != '0)
    `SC1A_ASSERT_NXT(a_prefix_armed, i_clk, i_rst_n, i_fire && is_prefix, r_prefix)
    `SC1A_ASSERT_NXT(a_state_holds, i_clk, i_rst_n, !i_fire,
                     $stable(r_prefix) && $stable(r_ctrl) && $stable(r_shift) &&
                     $stable(r_alt) && $stable(r_caps))
    `SC1A_ASSERT_NXT(a_caps_only_on_make, i_clk, i_rst_n, i_fire && (is_break || is_prefix),
                     $stable(r_caps))

endmodule

// ----- hw/rtl/sc1a_out_reg.sv -----
module sc1a_out_reg (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  sc1a_pkg::t_result       i_result,
    input  logic                    i_ready,
    output logic                    o_valid,
    output sc1a_pkg::t_result       o_result
);
    import sc1a_pkg::*;

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- hw/rtl/scancode_set1_to_ascii.sv -----
// Channel | Dir | tdata (low bit up)                         | tuser (low bit up)
// s_axis  | in  | scan_byte[7:0]                             | buffer_full
// m_axis  | out | char_code[6:0] ctrl shift alt caps, 0 pad  | char_valid unknown_key
//
// One item per cycle sustained while m_axis is not stalled; the path is the input
// register, then decode and table lookup into the result register.
// Reset (i_rst_n low, synchronous) clears the prefix flag and all modifiers.
// An m_axis stall holds the result register and the input register; s_axis
// keeps accepting until both hold an item.
module scancode_set1_to_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // scan_byte[7:0]
    input  logic [0:0]  s_axis_tuser,   // buffer_full
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // char_code[6:0], ctrl, shift, alt, caps, zeros
    output logic [1:0]  m_axis_tuser    // char_valid, unknown_key
);
    import sc1a_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_full;
    logic       advance;
    t_result    dec_result;
    t_result    out_result;

    // The input item moves on when the result register is free or draining.
    assign advance       = r_in_valid && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_full <= s_axis_tuser[0];
        end
    end

    sc1a_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_byte   (r_in_byte),
        .i_full   (r_in_full),
        .o_result (dec_result)
    );

    sc1a_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (dec_result),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_result (out_result)
    );

    assign m_axis_tdata = {5'b0, out_result.caps_on, out_result.alt_down,
                           out_result.shift_down, out_result.ctrl_down,
                           out_result.char_code};
    assign m_axis_tuser = {out_result.unknown_key, out_result.char_valid};

endmodule

// ----- test/scancode_result_checker.sv -----
`timescale 1ns / 1ps

module scancode_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // scan_byte[7:0]
    input  logic [0:0]  s_axis_tuser,   // buffer_full
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // char_code[6:0], ctrl, shift, alt, caps, zeros
    input  logic [1:0]  m_axis_tuser,   // char_valid, unknown_key
    output int          o_fail_count,
    output int          o_pending
);
    import sc1a_pkg::*;

    // Extended codes carry the prefix byte in the upper half.
    localparam logic [15:0] CTRL_CODE   = {8'h00, 1'b0, MK_CTRL};
    localparam logic [15:0] RCTRL_CODE  = {PREFIX_BYTE, 1'b0, MK_CTRL};
    localparam logic [15:0] LSHIFT_CODE = {8'h00, 1'b0, MK_LSHIFT};
    localparam logic [15:0] RSHIFT_CODE = {8'h00, 1'b0, MK_RSHIFT};
    localparam logic [15:0] ALT_CODE    = {8'h00, 1'b0, MK_ALT};
    localparam logic [15:0] RALT_CODE   = {PREFIX_BYTE, 1'b0, MK_ALT};
    localparam logic [15:0] LAST_CODE   = {8'h00, LAST_MAKE};

    // Key map, code 0x00 leftmost; a zero byte marks a modifier or unused code.
    localparam logic [59*8-1:0] PLAIN_KEYS = {
        8'h00, 8'h1B, "1234567890-=", 8'h08, 8'h09, "qwertyuiop[]", 8'h0D, 8'h00,
        "asdfghjkl;'", 8'h60, 8'h00, "\\zxcvbnm,./", 8'h00, "*", 8'h00, " ", 8'h00
    };
    localparam logic [59*8-1:0] SHIFTED_KEYS = {
        8'h00, 8'h1B, "!@#$%^&*()_+", 8'h08, 8'h09, "QWERTYUIOP{}", 8'h0D, 8'h00,
        "ASDFGHJKL:\"~", 8'h00, "|ZXCVBNM<>?", 8'h00, "*", 8'h00, " ", 8'h00
    };

    logic    ext_armed;
    logic    ctrl_held;
    logic    shift_held;
    logic    alt_held;
    logic    caps_toggle;
    t_result expected_keys [$];
    int      fail_count = 0;
    int      n_pending = 0;
    int      n_results = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = n_pending;

    function automatic logic follows_shift_only(input logic [15:0] code);
        return code < 16'h000E || code == 16'h001A || code == 16'h001B ||
               code == 16'h0027 || code == 16'h0028 || code == 16'h0029 ||
               code == 16'h002B || code == 16'h0033 || code == 16'h0034 ||
               code == 16'h0035;
    endfunction

    // Advances the modifier state by one scan byte and returns the item it yields.
    function automatic t_result decode_scan(input logic [7:0] sbyte, input logic full);
        t_result     res;
        logic [15:0] code;
        logic [15:0] mk;
        logic        upper;
        logic [7:0]  ch;
        int          idx;
        res = '0;
        if (sbyte == PREFIX_BYTE) begin
            ext_armed = 1'b1;
        end else begin
            code = {8'h00, sbyte};
            if (ext_armed) begin
                code[15:8] = PREFIX_BYTE;
                ext_armed  = 1'b0;
            end
            if (code[7]) begin
                mk = {code[15:8], 1'b0, code[6:0]};
                if (mk == CTRL_CODE || mk == RCTRL_CODE)
                    ctrl_held = 1'b0;
                else if (mk == LSHIFT_CODE || mk == RSHIFT_CODE)
                    shift_held = 1'b0;
                else if (mk == ALT_CODE || mk == RALT_CODE)
                    alt_held = 1'b0;
            end else if ((code != 16'h0000 && code <= LAST_CODE) ||
                         code == RALT_CODE || code == RCTRL_CODE) begin
                idx   = int'(code[5:0]);
                upper = follows_shift_only(code) ? shift_held : (shift_held ^ caps_toggle);
                ch    = upper ? SHIFTED_KEYS[(58 - idx) * 8 +: 8]
                              : PLAIN_KEYS[(58 - idx) * 8 +: 8];
                if (ch != 8'h00) begin
                    if (ctrl_held && (ch[6:0] == CH_LOWER_L || ch[6:0] == CH_LOWER_U))
                        ch = ch - {1'b0, CH_LOWER_A};
                    if (!full) begin
                        res.char_valid = 1'b1;
                        res.char_code  = ch[6:0];
                    end
                end else if (code[6:0] == MK_CTRL) begin
                    ctrl_held = 1'b1;
                end else if (code[6:0] == MK_LSHIFT || code[6:0] == MK_RSHIFT) begin
                    shift_held = 1'b1;
                end else if (code[6:0] == MK_ALT) begin
                    alt_held = 1'b1;
                end else if (code[6:0] == MK_CAPS) begin
                    caps_toggle = !caps_toggle;
                end
            end else begin
                res.unknown_key = 1'b1;
            end
        end
        res.ctrl_down  = ctrl_held;
        res.shift_down = shift_held;
        res.alt_down   = alt_held;
        res.caps_on    = caps_toggle;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("ERROR result %0d %s: got 0x%0h, expected 0x%0h", n_results, field, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            ext_armed   = 1'b0;
            ctrl_held   = 1'b0;
            shift_held  = 1'b0;
            alt_held    = 1'b0;
            caps_toggle = 1'b0;
            expected_keys.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.char_valid  = m_axis_tuser[0];
                got.unknown_key = m_axis_tuser[1];
                got.char_code   = m_axis_tdata[6:0];
                got.ctrl_down   = m_axis_tdata[7];
                got.shift_down  = m_axis_tdata[8];
                got.alt_down    = m_axis_tdata[9];
                got.caps_on     = m_axis_tdata[10];
                if (expected_keys.size() == 0) begin
                    report_mismatch("unexpected item", int'(m_axis_tdata), 0);
                end else begin
                    want = expected_keys.pop_front();
                    if (got.char_valid !== want.char_valid)
                        report_mismatch("char_valid", got.char_valid, want.char_valid);
                    if (got.char_code !== want.char_code)
                        report_mismatch("char_code", got.char_code, want.char_code);
                    if (got.unknown_key !== want.unknown_key)
                        report_mismatch("unknown_key", got.unknown_key, want.unknown_key);
                    if (got.ctrl_down !== want.ctrl_down)
                        report_mismatch("ctrl_down", got.ctrl_down, want.ctrl_down);
                    if (got.shift_down !== want.shift_down)
                        report_mismatch("shift_down", got.shift_down, want.shift_down);
                    if (got.alt_down !== want.alt_down)
                        report_mismatch("alt_down", got.alt_down, want.alt_down);
                    if (got.caps_on !== want.caps_on)
                        report_mismatch("caps_on", got.caps_on, want.caps_on);
                end
                n_results++;
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_keys.push_back(decode_scan(s_axis_tdata, s_axis_tuser[0]));
        end
        n_pending = expected_keys.size();
    end

endmodule

// ----- test/tb_scancode_set1_to_ascii.sv -----
`timescale 1ns / 1ps

module tb_scancode_set1_to_ascii;
    import sc1a_pkg::*;

    localparam int HOLD_CYCLES = 80;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int   fail_count;
    int   n_pending;
    int   src_idle_pct = 0;
    int   sink_idle_pct = 0;
    logic hold_req = 1'b0;

    // {buffer_full, scan_byte}
    logic [8:0] directed_keys [$] = '{
        {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, 8'h3B}, {1'b0, 8'h01}, {1'b0, 8'h02},
        {2'b00, MK_LSHIFT}, {1'b0, 8'h02}, {1'b0, 8'h10}, {2'b00, MK_CAPS},
        {1'b0, 8'h10}, {1'b0, 8'h02}, {2'b01, MK_LSHIFT}, {1'b0, 8'h10},
        {2'b00, MK_CAPS}, {2'b00, MK_CTRL}, {1'b0, 8'h26}, {1'b0, 8'h16},
        {2'b01, MK_CTRL}, {1'b0, PREFIX_BYTE}, {1'b0, PREFIX_BYTE}, {2'b00, MK_ALT},
        {1'b0, PREFIX_BYTE}, {2'b01, MK_ALT}, {1'b0, PREFIX_BYTE}, {1'b0, 8'h10},
        {1'b1, 8'h1E}
    };

    scancode_set1_to_ascii DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    scancode_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (n_pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Called and returns at a falling edge.
    task automatic send_scan(input logic [7:0] sbyte, input logic full);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sbyte;
        s_axis_tuser  <= full;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [6:0] pick_modifier(input logic with_shift);
        case ($urandom_range(with_shift ? 3 : 1))
            0:       return MK_CTRL;
            1:       return MK_ALT;
            2:       return MK_LSHIFT;
            default: return MK_RSHIFT;
        endcase
    endfunction

    // Mostly key presses and modifier traffic, with some raw noise.
    task automatic run_random(input int n_items);
        int         sent;
        int         pick;
        logic       full;
        logic [6:0] mk;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            full = ($urandom_range(99) < 15);
            if (pick < 48) begin
                send_scan(8'($urandom_range(58) + 1), full);
                sent += 1;
            end else if (pick < 58) begin
                if ($urandom_range(3) == 0) begin
                    send_scan(PREFIX_BYTE, full);
                    send_scan({1'b0, pick_modifier(1'b0)}, full);
                    sent += 2;
                end else begin
                    mk = ($urandom_range(4) == 0) ? MK_CAPS : pick_modifier(1'b1);
                    send_scan({1'b0, mk}, full);
                    sent += 1;
                end
            end else if (pick < 70) begin
                if ($urandom_range(3) == 0) begin
                    send_scan(PREFIX_BYTE, full);
                    send_scan({1'b1, pick_modifier(1'b1)}, full);
                    sent += 2;
                end else begin
                    send_scan({1'b1, pick_modifier(1'b1)}, full);
                    sent += 1;
                end
            end else if (pick < 78) begin
                send_scan({1'b1, 7'($urandom_range(8'h3A))}, full);
                sent += 1;
            end else if (pick < 84) begin
                send_scan(PREFIX_BYTE, full);
                send_scan(8'($urandom_range(255)), full);
                sent += 2;
            end else begin
                send_scan(8'($urandom_range(255)), full);
                sent += 1;
            end
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                for (int k = 0; k < HOLD_CYCLES; k++) begin
                    m_axis_tready <= 1'b0;
                    @(negedge i_clk);
                end
                hold_req = 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        src_idle_pct  = 14;
        sink_idle_pct = 48;
        foreach (directed_keys[i])
            send_scan(directed_keys[i][7:0], directed_keys[i][8]);
        run_random(300);

        // back-to-back items into a stalled output
        src_idle_pct = 0;
        hold_req     = 1'b1;
        run_random(40);

        src_idle_pct  = 48;
        sink_idle_pct = 14;
        run_random(300);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_random(300);

        s_axis_tvalid <= 1'b0;
        while (n_pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/sc1a_pkg.sv
hw/rtl/sc1a_decode.sv
hw/rtl/sc1a_out_reg.sv
hw/rtl/scancode_set1_to_ascii.sv
test/scancode_result_checker.sv
test/tb_scancode_set1_to_ascii.sv
